// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/psd_pkg.sv =====
// Package for the point to segment distance block: widths and payload types.
// No dependencies.
package psd_pkg;

  localparam int COORD_BITS = 20;
  localparam int DIST_BITS  = 21;
  // squared sums (den, |w|^2, |v|^2), divider remainder and quotient
  localparam int DW = 2 * COORD_BITS + 2;
  // magnitude of one cross product component
  localparam int CW = 2 * COORD_BITS + 1;
  // low half of the cross component split for squaring
  localparam int HW = COORD_BITS + 1;
  // numerator |w x d|^2
  localparam int NW = 2 * DW;
  // root bits and square root remainder
  localparam int RB = COORD_BITS + 1;
  localparam int RW = RB + 2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    logic [DW-1:0] quo;
    logic [DW-1:0] alt;
    logic          hit;
  } div_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] rad;
    logic [RB-1:0] root;
    logic          hit;
  } sqrt_t;

endpackage

// ===== rtl/core/psd_if.sv =====
// Channel interfaces of the point to segment distance block.
// Depends on psd_pkg for the coordinate and distance widths.
interface psd_query_if;
  logic                   valid;
  logic                   ready;
  logic [psd_pkg::COORD_BITS-1:0] point_x;
  logic [psd_pkg::COORD_BITS-1:0] point_y;
  logic [psd_pkg::COORD_BITS-1:0] point_z;
  logic [psd_pkg::COORD_BITS-1:0] end_a_x;
  logic [psd_pkg::COORD_BITS-1:0] end_a_y;
  logic [psd_pkg::COORD_BITS-1:0] end_a_z;
  logic [psd_pkg::COORD_BITS-1:0] end_b_x;
  logic [psd_pkg::COORD_BITS-1:0] end_b_y;
  logic [psd_pkg::COORD_BITS-1:0] end_b_z;

  modport source (output valid, point_x, point_y, point_z, end_a_x, end_a_y, end_a_z,
                  end_b_x, end_b_y, end_b_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, end_a_x, end_a_y, end_a_z,
                end_b_x, end_b_y, end_b_z, output ready);
endinterface

interface psd_result_if;
  logic                          valid;
  logic                          ready;
  logic [psd_pkg::DIST_BITS-1:0] seg_distance;
  logic                          hit_interior;

  modport source (output valid, seg_distance, hit_interior, input ready);
  modport sink (input valid, seg_distance, hit_interior, output ready);
endinterface

// ===== rtl/core/point_segment_distance_3d_top.sv =====
// Point to segment distance, top level: front pipeline, divider and root chains, output.
// Depends on psd_pkg, psd_if, psd_front, psd_div_cell, psd_sqrt_cell, assert_macros.svh.
//
// Returns floor(sqrt(d^2)) of the squared distance from point P to segment AB, as
// an unsigned integer with 0 fractional bits, and hit_interior when the projection
// of P falls inside the segment (ends included). Fully pipelined: one transaction is
// accepted every cycle while the pipeline is not stalled. The path is 6 front stages,
// 42 divider cells at one quotient bit each, 21 root cells at one root bit each, and
// the output register. A zero-length segment returns the distance to A. The pipeline
// stalls only when the result is not taken and the two-entry output buffer fills;
// query ready then drops until the buffer drains.

`include "assert_macros.svh"

module point_segment_distance_3d_top (
  input  logic           clk,
  input  logic           rst,
  psd_query_if.sink      query,
  psd_result_if.source   result
);

  localparam int DW = psd_pkg::DW;
  localparam int RB = psd_pkg::RB;

  logic              en;
  logic              skid_valid;
  logic [psd_pkg::DIST_BITS-1:0] skid_dist;
  logic              skid_hit;

  psd_pkg::vec_t     pv, av, bv;

  // divider chain, entry 0 is the front output
  logic              dv [DW+1];
  psd_pkg::div_t     dd [DW+1];

  // root chain, entry 0 selects the radicand
  logic              sv [RB+1];
  psd_pkg::sqrt_t    sd [RB+1];

  logic              take_out;
  logic              leave;
  logic [psd_pkg::DIST_BITS-1:0] last_dist;

  // the pipeline moves whenever the skid slot is empty
  assign en          = !skid_valid;
  assign query.ready = en;

  assign pv = '{x: query.point_x, y: query.point_y, z: query.point_z};
  assign av = '{x: query.end_a_x, y: query.end_a_y, z: query.end_a_z};
  assign bv = '{x: query.end_b_x, y: query.end_b_y, z: query.end_b_z};

  psd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (query.valid),
    .p        (pv),
    .a        (av),
    .b        (bv),
    .out_valid(dv[0]),
    .out_data (dd[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_div
    psd_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv[i]),
      .in_data  (dd[i]),
      .out_valid(dv[i+1]),
      .out_data (dd[i+1])
    );
  end

  // interior: |w x d|^2 / |d|^2; otherwise the nearer endpoint's squared distance
  assign sv[0]      = dv[DW];
  assign sd[0].rem  = '0;
  assign sd[0].rad  = dd[DW].hit ? dd[DW].quo : dd[DW].alt;
  assign sd[0].root = '0;
  assign sd[0].hit  = dd[DW].hit;

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sv[i]),
      .in_data  (sd[i]),
      .out_valid(sv[i+1]),
      .out_data (sd[i+1])
    );
  end

  assign last_dist = psd_pkg::DIST_BITS'(sd[RB].root);
  assign take_out  = !result.valid || result.ready;
  assign leave     = sv[RB] && en;

  // output register plus one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take_out) begin
      if (skid_valid) begin
        result.valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result.valid <= leave;
      end
    end else if (leave) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      if (skid_valid) begin
        result.seg_distance <= skid_dist;
        result.hit_interior <= skid_hit;
      end else begin
        result.seg_distance <= last_dist;
        result.hit_interior <= sd[RB].hit;
      end
    end else if (leave) begin
      skid_dist <= last_dist;
      skid_hit  <= sd[RB].hit;
    end
  end

  // a transaction sits in the skid slot only behind a held result
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, result.valid)
  // a stalled result with a finished item behind it fills the skid slot
  `ASSERT_NEXT(a_skid_catch, clk, rst, result.valid && !result.ready && sv[RB], skid_valid)
  // the skid slot drains as soon as the result is taken
  `ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && result.ready, !skid_valid && result.valid)

endmodule

// ===== rtl/core/psd_front.sv =====
// Front pipeline: differences, products, squared sums, range test, |w x d|^2.
// Depends on psd_pkg; feeds the first divider cell.
module psd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  psd_pkg::vec_t     p,
  input  psd_pkg::vec_t     a,
  input  psd_pkg::vec_t     b,
  output logic              out_valid,
  output psd_pkg::div_t     out_data
);

  localparam int CB = psd_pkg::COORD_BITS;
  localparam int DW = psd_pkg::DW;
  localparam int CW = psd_pkg::CW;
  localparam int HW = psd_pkg::HW;
  localparam int NW = psd_pkg::NW;

  typedef logic signed [CB:0]     diff_t;
  typedef logic signed [2*CB+1:0] prod_t;

  function automatic diff_t sdiff(input psd_pkg::coord_t x, input psd_pkg::coord_t y);
    sdiff = diff_t'({1'b0, x}) - diff_t'({1'b0, y});
  endfunction

  logic [5:0] vld;

  // stage 1: w = P-A, d = B-A, u = P-B
  diff_t w1 [3];
  diff_t d1 [3];
  diff_t u1 [3];

  // stage 2: products
  prod_t wsq2 [3];
  prod_t dsq2 [3];
  prod_t usq2 [3];
  prod_t dot2 [3];
  prod_t crs2 [6];

  // stage 3: sums
  logic [DW-1:0]        den3, wsq3, usq3;
  logic signed [DW:0]   dot3;
  logic [CW-1:0]        cm3 [3];

  // stage 4: split squares and range decision
  logic [2*(CW-HW)-1:0] hh4 [3];
  logic [CW-1:0]        hl4 [3];
  logic [2*HW-1:0]      ll4 [3];
  logic [DW-1:0]        den4, alt4;
  logic                 hit4;

  // stage 5: per-axis squares
  logic [2*CW-1:0]      sq5 [3];
  logic [DW-1:0]        den5, alt5;
  logic                 hit5;

  // stage 6
  logic [NW-1:0]        num6;
  logic [DW-1:0]        den6, alt6;
  logic                 hit6;

  logic signed [DW:0]   c3 [3];
  logic [DW-1:0]        alt_c;
  logic                 hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_comb begin
    c3[0] = (DW+1)'(crs2[0]) - (DW+1)'(crs2[1]);
    c3[1] = (DW+1)'(crs2[2]) - (DW+1)'(crs2[3]);
    c3[2] = (DW+1)'(crs2[4]) - (DW+1)'(crs2[5]);
    if (den3 == '0) begin
      alt_c = wsq3;
    end else if (wsq3 < usq3) begin
      alt_c = wsq3;
    end else begin
      alt_c = usq3;
    end
    hit_c = (den3 != '0) && !dot3[DW] && (dot3 <= $signed({1'b0, den3}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1[0] <= sdiff(p.x, a.x);
      w1[1] <= sdiff(p.y, a.y);
      w1[2] <= sdiff(p.z, a.z);
      d1[0] <= sdiff(b.x, a.x);
      d1[1] <= sdiff(b.y, a.y);
      d1[2] <= sdiff(b.z, a.z);
      u1[0] <= sdiff(p.x, b.x);
      u1[1] <= sdiff(p.y, b.y);
      u1[2] <= sdiff(p.z, b.z);

      for (int k = 0; k < 3; k++) begin
        wsq2[k] <= w1[k] * w1[k];
        dsq2[k] <= d1[k] * d1[k];
        usq2[k] <= u1[k] * u1[k];
        dot2[k] <= w1[k] * d1[k];
      end
      // w x d components as product pairs
      crs2[0] <= w1[1] * d1[2];
      crs2[1] <= w1[2] * d1[1];
      crs2[2] <= w1[2] * d1[0];
      crs2[3] <= w1[0] * d1[2];
      crs2[4] <= w1[0] * d1[1];
      crs2[5] <= w1[1] * d1[0];

      den3 <= DW'(dsq2[0]) + DW'(dsq2[1]) + DW'(dsq2[2]);
      wsq3 <= DW'(wsq2[0]) + DW'(wsq2[1]) + DW'(wsq2[2]);
      usq3 <= DW'(usq2[0]) + DW'(usq2[1]) + DW'(usq2[2]);
      dot3 <= (DW+1)'(dot2[0]) + (DW+1)'(dot2[1]) + (DW+1)'(dot2[2]);
      for (int k = 0; k < 3; k++) begin
        cm3[k] <= c3[k][DW] ? CW'(-c3[k]) : CW'(c3[k]);
      end

      for (int k = 0; k < 3; k++) begin
        hh4[k] <= cm3[k][CW-1:HW] * cm3[k][CW-1:HW];
        hl4[k] <= cm3[k][CW-1:HW] * cm3[k][HW-1:0];
        ll4[k] <= cm3[k][HW-1:0] * cm3[k][HW-1:0];
      end
      den4 <= den3;
      alt4 <= alt_c;
      hit4 <= hit_c;

      for (int k = 0; k < 3; k++) begin
        sq5[k] <= ((2*CW)'(hh4[k]) << (2*HW)) + ((2*CW)'(hl4[k]) << (HW+1))
                  + (2*CW)'(ll4[k]);
      end
      den5 <= den4;
      alt5 <= alt4;
      hit5 <= hit4;

      num6 <= NW'(sq5[0]) + NW'(sq5[1]) + NW'(sq5[2]);
      den6 <= den5;
      alt6 <= alt5;
      hit6 <= hit5;
    end
  end

  assign out_valid     = vld[5];
  assign out_data.rem  = num6[NW-1:DW];
  assign out_data.num  = num6[DW-1:0];
  assign out_data.den  = den6;
  assign out_data.quo  = '0;
  assign out_data.alt  = alt6;
  assign out_data.hit  = hit6;

endmodule

// ===== rtl/core/psd_div_cell.sv =====
// One restoring divider cell: produces one quotient bit per cycle while en is high.
// Depends on psd_pkg for div_t.
module psd_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  psd_pkg::div_t in_data,
  output logic          out_valid,
  output psd_pkg::div_t out_data
);

  localparam int DW = psd_pkg::DW;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        take;

  always_comb begin
    trial = {in_data.rem, in_data.num[DW-1]};
    diff  = trial - {1'b0, in_data.den};
    take  = (trial >= {1'b0, in_data.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rem <= take ? diff[DW-1:0] : trial[DW-1:0];
      out_data.num <= {in_data.num[DW-2:0], 1'b0};
      out_data.den <= in_data.den;
      out_data.quo <= {in_data.quo[DW-2:0], take};
      out_data.alt <= in_data.alt;
      out_data.hit <= in_data.hit;
    end
  end

endmodule

// ===== rtl/core/psd_sqrt_cell.sv =====
// One digit-recurrence square root cell: one root bit per cycle while en is high.
// Depends on psd_pkg for sqrt_t.
module psd_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  psd_pkg::sqrt_t in_data,
  output logic           out_valid,
  output psd_pkg::sqrt_t out_data
);

  localparam int DW = psd_pkg::DW;
  localparam int RB = psd_pkg::RB;
  localparam int RW = psd_pkg::RW;

  logic [RW+1:0] acc;
  logic [RW+1:0] trial;
  logic          take;

  always_comb begin
    acc   = {in_data.rem, in_data.rad[DW-1:DW-2]};
    trial = (RW+2)'({in_data.root, 2'b01});
    take  = (acc >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rem  <= take ? RW'(acc - trial) : RW'(acc);
      out_data.rad  <= {in_data.rad[DW-3:0], 2'b00};
      out_data.root <= {in_data.root[RB-2:0], take};
      out_data.hit  <= in_data.hit;
    end
  end

endmodule

// ===== tb/psd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the point to segment distance block: watches both channels, works out
// the expected distance per query and compares results in order. Depends on psd_pkg, psd_if.
module psd_checker (
  input  logic  clk,
  input  logic  rst,
  psd_query_if  query,
  psd_result_if result,
  output int    error_count,
  output int    outstanding
);

  typedef struct {
    logic [psd_pkg::DIST_BITS-1:0] distance;
    logic                          hit;
  } dist_result_t;

  dist_result_t expected_dist_q[$];

  function automatic logic [psd_pkg::DIST_BITS-1:0] floor_root(logic [127:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = 0;
    for (int i = 22; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
    end
    return res[psd_pkg::DIST_BITS-1:0];
  endfunction

  function automatic dist_result_t segment_distance(psd_pkg::vec_t p, psd_pkg::vec_t a,
                                                    psd_pkg::vec_t b);
    psd_pkg::coord_t pv[3];
    psd_pkg::coord_t av[3];
    psd_pkg::coord_t bv[3];
    longint          d, w, v, den, wsq, vsq, dot;
    logic [127:0]    num, nearest;
    dist_result_t    r;
    pv = '{p.x, p.y, p.z};
    av = '{a.x, a.y, a.z};
    bv = '{b.x, b.y, b.z};
    den = 0; wsq = 0; vsq = 0; dot = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'({44'd0, bv[k]}) - longint'({44'd0, av[k]});
      w = longint'({44'd0, pv[k]}) - longint'({44'd0, av[k]});
      v = longint'({44'd0, pv[k]}) - longint'({44'd0, bv[k]});
      den += d * d;
      wsq += w * w;
      vsq += v * v;
      dot += d * w;
    end
    nearest = (wsq < vsq) ? 128'(wsq) : 128'(vsq);
    r.hit = 1'b0;
    if (den == 0) begin
      // degenerate segment: distance to A
      r.distance = floor_root(128'(wsq));
    end else if (dot < 0 || dot > den) begin
      r.distance = floor_root(nearest);
    end else begin
      num = 128'(wsq) * 128'(den) - 128'(dot) * 128'(dot);
      r.distance = floor_root(num / 128'(den));
      r.hit = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    psd_pkg::vec_t p, a, b;
    dist_result_t  exp_r;
    if (!rst) begin
      if (query.valid && query.ready) begin
        p = '{query.point_x, query.point_y, query.point_z};
        a = '{query.end_a_x, query.end_a_y, query.end_a_z};
        b = '{query.end_b_x, query.end_b_y, query.end_b_z};
        expected_dist_q.push_back(segment_distance(p, a, b));
      end
      if (result.valid && result.ready) begin
        if (expected_dist_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result dist=%0d hit=%0b", $realtime,
                     result.seg_distance, result.hit_interior);
        end else begin
          exp_r = expected_dist_q.pop_front();
          if (result.seg_distance !== exp_r.distance ||
              result.hit_interior !== exp_r.hit) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: mismatch dist exp=%0d got=%0d, hit exp=%0b got=%0b",
                       $realtime, exp_r.distance, result.seg_distance, exp_r.hit,
                       result.hit_interior);
          end
        end
      end
    end
    outstanding <= expected_dist_q.size();
  end
endmodule

// ===== tb/tb_point_segment_distance_3d_top.sv =====
`timescale 1ns / 100ps
// Testbench top for point_segment_distance_3d_top: query stimulus, receiver stalls, verdict.
// Depends on psd_pkg, psd_if, psd_checker and the block itself.
module tb_point_segment_distance_3d_top;

  logic clk;
  logic rst;
  int   error_count;
  int   outstanding;
  int   sender_idle_pct;
  int   receiver_stall_pct;

  psd_query_if  query ();
  psd_result_if result ();

  point_segment_distance_3d_top dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query),
    .result (result)
  );

  psd_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .query       (query),
    .result      (result),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stall per cycle, rate set by the current phase
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Drive one query and hold it until the transaction is taken. Afterwards the
  // sender may go idle for a random stretch; valid is only lowered when it does,
  // so back-to-back queries keep valid high across the edge.
  task automatic send_query(psd_pkg::vec_t p, psd_pkg::vec_t a, psd_pkg::vec_t b);
    int gap;
    query.valid   <= 1'b1;
    query.point_x <= p.x;
    query.point_y <= p.y;
    query.point_z <= p.z;
    query.end_a_x <= a.x;
    query.end_a_y <= a.y;
    query.end_a_z <= a.z;
    query.end_b_x <= b.x;
    query.end_b_y <= b.y;
    query.end_b_z <= b.z;
    do @(posedge clk); while (!query.ready);
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      query.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic psd_pkg::vec_t splat(psd_pkg::coord_t c);
    return '{c, c, c};
  endfunction

  function automatic psd_pkg::coord_t rand_coord();
    return psd_pkg::coord_t'($urandom());
  endfunction

  // coordinate within a small window around base, clamped to the field range
  function automatic psd_pkg::coord_t near_coord(psd_pkg::coord_t base, int span);
    longint v;
    v = longint'({44'd0, base}) + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > (1 << psd_pkg::COORD_BITS) - 1) v = (1 << psd_pkg::COORD_BITS) - 1;
    return psd_pkg::coord_t'(v);
  endfunction

  // Random query, mostly geometry that exercises the projection: local clusters
  // (mixed interior and end-cap hits), points near the midpoint, points on an
  // endpoint (t = 0 or 1), degenerate segments, and some plain noise.
  task automatic send_random_query();
    psd_pkg::vec_t p, a, b, m;
    int            kind;
    int            span;
    kind = $urandom_range(9);
    span = ($urandom_range(3) == 0) ? 200000 : 2000;
    a = '{rand_coord(), rand_coord(), rand_coord()};
    b = '{near_coord(a.x, span), near_coord(a.y, span), near_coord(a.z, span)};
    p = '{near_coord(a.x, span), near_coord(a.y, span), near_coord(a.z, span)};
    case (kind)
      0, 1: begin
        b = '{rand_coord(), rand_coord(), rand_coord()};
        p = '{rand_coord(), rand_coord(), rand_coord()};
      end
      2: b = a;
      3, 4: begin
        m = '{psd_pkg::coord_t'((21'(a.x) + 21'(b.x)) >> 1),
              psd_pkg::coord_t'((21'(a.y) + 21'(b.y)) >> 1),
              psd_pkg::coord_t'((21'(a.z) + 21'(b.z)) >> 1)};
        p = '{near_coord(m.x, 50), near_coord(m.y, 50), near_coord(m.z, 50)};
      end
      5: p = ($urandom_range(1) == 0) ? a : b;
      default: ;
    endcase
    send_query(p, a, b);
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int idle_table[4];
    int stall_table[4];
    idle_table  = '{0, 81, 0, 6};
    stall_table = '{0, 0, 81, 6};
    rst                = 1'b1;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    query.valid        = 1'b0;
    query.point_x      = '0;
    query.point_y      = '0;
    query.point_z      = '0;
    query.end_a_x      = '0;
    query.end_a_y      = '0;
    query.end_a_z      = '0;
    query.end_b_x      = '0;
    query.end_b_y      = '0;
    query.end_b_z      = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, degenerate segment, t at 0 and 1, caps on each side
    send_query(splat('0), splat('0), splat('0));
    send_query(splat('1), splat('1), splat('1));
    send_query(splat('1), splat('0), splat('0));          // zero length, far point
    send_query(splat('0), splat('1), splat('1));
    send_query(splat('0), splat('0), splat('1));          // t = 0
    send_query(splat('1), splat('0), splat('1));          // t = 1
    send_query('{20'hFFFFF, 20'h0, 20'h0}, splat('0), splat('1)); // interior, long diagonal
    send_query(splat(20'h80000), splat('0), splat('1));   // midpoint on the line
    send_query(splat('1), splat('0), splat(20'h80000));   // past B
    send_query(splat('0), splat(20'h80000), splat('1));   // before A
    send_query(splat(20'hAAAAA), splat(20'h55555), '{20'hFFFFF, 20'h0, 20'hAAAAA});
    send_query(splat(20'h55555), '{20'h0, 20'hFFFFF, 20'h0}, '{20'hFFFFF, 20'h0, 20'hFFFFF});
    send_query('{20'h1, 20'h0, 20'h0}, splat('0), '{20'h0, 20'h1, 20'h0}); // sub-LSB
    send_query('{20'h100, 20'h100, 20'h0}, splat('0), '{20'h200, 20'h0, 20'h0});
    send_query('{20'h0, 20'hFFFFF, 20'hFFFFF}, '{20'hFFFFF, 20'h0, 20'h0},
               '{20'hFFFFF, 20'h0, 20'h1});
    send_query('{20'h12345, 20'hFEDCB, 20'h0}, '{20'h0, 20'hFFFFF, 20'h0},
               '{20'hFFFFF, 20'h0, 20'hFFFFF});

    // random phases with different idle / stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = idle_table[ph];
      receiver_stall_pct = stall_table[ph];
      repeat (210) send_random_query();
      if (ph == 1) begin
        // hold the sender off until the pipeline has fully drained
        query.valid <= 1'b0;
        wait_drained();
      end
    end
    query.valid <= 1'b0;

    // drain, then a margin of the pipeline latency
    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("tb_point_segment_distance_3d_top: PASS");
    end else begin
      $display("tb_point_segment_distance_3d_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_point_segment_distance_3d_top: FAIL");
    $finish;
  end
endmodule
